// File: rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
`default_nettype none
package sha_pkg;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned BLOCK_WORDS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_FINISH,
        ST_PAD2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_byte;
        logic start_compress;
        logic pad_final;
        logic pad_length;
        logic reset_chain;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic block_full;
        logic pad_two_blocks;
        logic emit_done;
    } t_status;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] a);
        big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] e);
        big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] w);
        small_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] w);
        small_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
    endfunction

endpackage
`default_nettype wire

// File: rtl/sha_ctrl.sv
// Controller state machine that sequences absorb, compression, padding and digest output.
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_has_byte,
    input  wire logic    i_end_of_message,
    output logic         o_stall,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_pending_end;
    logic   n_pending_end;
    logic   accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pending_end <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pending_end <= n_pending_end;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pending_end = r_pending_end;
        o_cmd         = '0;
        o_stall       = (r_state != ST_IDLE);
        o_out_valid   = (r_state == ST_EMIT);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_byte = i_has_byte;
                    if (i_has_byte && i_status.block_full) begin
                        o_cmd.start_compress = 1'b1;
                        n_pending_end        = i_end_of_message;
                        n_state              = ST_COMPRESS;
                    end else if (i_end_of_message) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_COMPRESS: begin
                if (!i_status.busy) begin
                    if (r_pending_end) begin
                        n_pending_end = 1'b0;
                        n_state       = ST_FINISH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FINISH: begin
                o_cmd.pad_final      = 1'b1;
                o_cmd.start_compress = 1'b1;
                o_cmd.pad_length     = !i_status.pad_two_blocks;
                n_state              = i_status.pad_two_blocks ? ST_PAD2 : ST_EMIT;
                n_pending_end        = 1'b0;
            end
            ST_PAD2: begin
                if (!i_status.busy) begin
                    o_cmd.pad_length     = 1'b1;
                    o_cmd.start_compress = 1'b1;
                    n_state              = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = !i_status.busy;
                if (!i_status.busy && !i_out_stall) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_status.emit_done) begin
                        o_cmd.reset_chain = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/sha_dp.sv
// Datapath with block buffer, message schedule, round unit and chaining words.
`default_nettype none
module sha_dp
    import sha_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_data_byte,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);

    logic [31:0] r_block [BLOCK_WORDS];
    logic [31:0] r_sched [BLOCK_WORDS];
    logic [31:0] r_chain [DIGEST_WORDS];
    logic [31:0] r_work  [DIGEST_WORDS];
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_fold;
    logic [2:0]  r_emit;

    logic [31:0] wv;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [3:0]  ri;
    logic [3:0]  pw;
    logic [4:0]  sh;

    assign ri = r_round[3:0];
    assign pw = r_pos[5:2];
    assign sh = {~r_pos[1:0], 3'b000};

    always_comb begin
        if (r_round < 6'd16) begin
            wv = r_sched[ri];
        end else begin
            wv = small_s1(r_sched[ri - 4'd2]) + r_sched[ri - 4'd7]
               + small_s0(r_sched[ri - 4'd15]) + r_sched[ri];
        end
        t1 = r_work[7] + big_s1(r_work[4])
           + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6])) + K[r_round] + wv;
        t2 = big_s0(r_work[0])
           + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]));
    end

    assign o_status.busy           = r_busy || r_fold;
    assign o_status.block_full     = (r_pos == 6'd63);
    assign o_status.pad_two_blocks = (r_pos >= 6'd56);
    assign o_status.emit_done      = (r_emit == 3'd7);
    assign o_digest_word           = r_chain[r_emit];
    assign o_word_index            = r_emit;
    assign o_last_word             = (r_emit == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_bits  <= '0;
            r_busy  <= 1'b0;
            r_fold  <= 1'b0;
            r_round <= '0;
            r_emit  <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) r_chain[i] <= H_INIT[i];
        end else begin
            if (i_cmd.load_byte) begin
                r_block[pw] <= (r_block[pw] & ~(32'hff << sh))
                             | ({24'd0, i_data_byte} << sh);
                r_pos  <= r_pos + 6'd1;
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.start_compress) begin
                for (int i = 0; i < DIGEST_WORDS; i++) r_work[i] <= r_chain[i];
                r_busy  <= 1'b1;
                r_round <= '0;
                if (i_cmd.pad_final) begin
                    // Padding byte plus zeros after the last message byte.
                    for (int i = 0; i < BLOCK_WORDS; i++) begin
                        if (i < pw) r_sched[i] <= r_block[i];
                        else if (i == pw)
                            r_sched[i] <= (r_block[i] & ~(32'hffffffff >> (5'd24 - sh)))
                                        | ({24'd0, PAD_BYTE} << sh);
                        else r_sched[i] <= '0;
                    end
                    if (i_cmd.pad_length) begin
                        r_sched[14] <= r_bits[63:32];
                        r_sched[15] <= r_bits[31:0];
                    end
                    r_pos <= '0;
                end else if (i_cmd.pad_length) begin
                    for (int i = 0; i < 14; i++) r_sched[i] <= '0;
                    r_sched[14] <= r_bits[63:32];
                    r_sched[15] <= r_bits[31:0];
                end else begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) r_sched[i] <= r_block[i];
                    r_sched[15] <= (r_block[15] & 32'hffffff00) | {24'd0, i_data_byte};
                end
            end
            if (r_busy) begin
                if (r_round >= 6'd16) r_sched[ri] <= wv;
                r_work[0] <= t1 + t2;
                r_work[1] <= r_work[0];
                r_work[2] <= r_work[1];
                r_work[3] <= r_work[2];
                r_work[4] <= r_work[3] + t1;
                r_work[5] <= r_work[4];
                r_work[6] <= r_work[5];
                r_work[7] <= r_work[6];
                r_round   <= r_round + 6'd1;
                if (r_round == 6'(ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end
            if (r_fold) begin
                r_fold <= 1'b0;
                for (int i = 0; i < DIGEST_WORDS; i++) r_chain[i] <= r_chain[i] + r_work[i];
            end
            if (i_cmd.emit_next) begin
                r_emit <= r_emit + 3'd1;
            end
            if (i_cmd.reset_chain) begin
                for (int i = 0; i < DIGEST_WORDS; i++) r_chain[i] <= H_INIT[i];
                r_pos  <= '0;
                r_bits <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher joining controller and datapath.
// A byte that does not complete a block is taken without stalling input.
// A block-completing byte stalls input through 64 rounds, the fold and the return to idle.
// The end of a message adds one or two padding compressions, then 8 digest words.
// Input waits during every compression, since all rounds share the single round unit.
// Synchronous active-low reset loads the initial hash values and clears counters.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    t_cmd    cmd;
    t_status status;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
`default_nettype wire

// File: rtl/sha_checker.sv
// Port-level checker for the SHA-256 stream hasher and its bind statement.
`default_nettype none
module sha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag disagrees with index");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=> (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word index did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled digest word changed");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted during digest output");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);
`default_nettype wire
